// File: design/tes_pkg.sv
// Shared constants, codes and controller/datapath bundles for the tab stop converter.
`default_nettype none

package tes_pkg;

   // Character codes and field widths
   localparam int BYTE_W     = 8;
   localparam int CSR_DATA_W = 7;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
   localparam logic [BYTE_W-1:0] CH_FILL  = 8'd255;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
   localparam logic [BYTE_W-1:0] CH_NONE  = 8'd0;

   // Tab width limits and reset values
   localparam int MAX_TAB_WIDTH_DEFAULT = 64;
   localparam int TAB_WIDTH_RESET       = 8;

   // Conversion modes
   typedef enum logic [1:0] {
      MODE_EXPAND,
      MODE_STRIP,
      MODE_FIX,
      MODE_REPLACE
   } mode_type;

   localparam mode_type MODE_RESET = MODE_FIX;

   // Register indexes
   typedef enum logic [0:0] {
      CSR_TAB_WIDTH,
      CSR_MODE
   } csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;     // take the input word and load its first result
      logic fill_word;  // load the next filler of a tab run
      logic red_step;   // one compare/subtract step of the phase reduction
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic can_load;   // output register is free this cycle
      logic tab_run;    // current input is a tab that needs fillers after it
      logic fill_last;  // one filler left in the run
      logic red_done;   // reduction is on its last step
   } status_type;

endpackage

`default_nettype wire

// File: design/tes_if.sv
// Valid/ready channel interfaces for the input, result and register write ports.
`default_nettype none

interface tes_req_if
   import tes_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              end_of_string;

   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface tes_rsp_if
   import tes_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              has_byte;
   logic              last_of_run;
   logic              out_end_of_string;

   modport source (output valid, output out_byte, output has_byte, output last_of_run,
                   output out_end_of_string, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input last_of_run,
                   input out_end_of_string, output ready);
endinterface

interface tes_csr_if
   import tes_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/tes_ctrl.sv
// Sequencer: input acceptance, tab filler runs and phase reduction after a width write.
`default_nettype none

module tes_ctrl
   import tes_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       csr_width_wr,
   input  wire status_type status,
   output logic            req_ready,
   output logic            csr_ready,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FILL,
      S_REDUCE
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Handshakes and commands follow from the state
   always_comb begin
      req_ready     = (state_ff == S_IDLE) && status.can_load;
      csr_ready     = (state_ff != S_REDUCE);
      cmd.accept    = req_valid && req_ready;
      cmd.fill_word = (state_ff == S_FILL) && status.can_load;
      cmd.red_step  = (state_ff == S_REDUCE);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_width_wr) begin
               state_in = S_REDUCE;
            end else if (cmd.accept && status.tab_run) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (cmd.fill_word && status.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_REDUCE: begin
            if (status.red_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A tab run is entered only with an output register free to take its tab
   a_fill_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && state_in == S_FILL) |-> cmd.accept)
      else $error("filler run entered without an accepted tab");

   // Nothing is accepted while the phase is being reduced
   a_no_accept_reduce: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REDUCE) |-> !req_ready && !csr_ready)
      else $error("port open during phase reduction");

   // A width write in the idle state always leads into the reduction
   a_width_reduce: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && csr_width_wr) |=> (state_ff == S_REDUCE))
      else $error("width write did not start the phase reduction");

endmodule

`default_nettype wire

// File: design/tes_dp.sv
// Datapath: registers, column phase, filler counter, phase reduction and output word.
`default_nettype none

module tes_dp
   import tes_pkg::*;
#(
   parameter int MAX_TAB_WIDTH = MAX_TAB_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   // register writes
   input  wire logic                  csr_wr,
   input  wire csr_index_type         csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   // input word
   input  wire logic [BYTE_W-1:0]     in_byte,
   input  wire logic                  in_eos,
   // result word
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [BYTE_W-1:0]          out_byte,
   output logic                       has_byte,
   output logic                       last_of_run,
   output logic                       out_eos
);

   localparam int PHASE_W = (MAX_TAB_WIDTH > 1) ? $clog2(MAX_TAB_WIDTH) : 1;
   localparam int WIDTH_W = $clog2(MAX_TAB_WIDTH + 1);
   localparam int WIDE_W  = PHASE_W + WIDTH_W;
   localparam int SH_W    = (PHASE_W > 1) ? $clog2(PHASE_W) : 1;
   localparam int RESET_WIDTH = (TAB_WIDTH_RESET > MAX_TAB_WIDTH) ?
                                MAX_TAB_WIDTH : TAB_WIDTH_RESET;
   localparam logic [CSR_DATA_W-1:0] MAX_RAW = CSR_DATA_W'(MAX_TAB_WIDTH);

   logic [WIDTH_W-1:0] width_ff, width_in;
   mode_type           mode_ff, mode_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [PHASE_W-1:0] fill_cnt_ff, fill_cnt_in;
   logic               eos_hold_ff, eos_hold_in;
   logic [SH_W-1:0]    shift_ff, shift_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               has_byte_ff, has_byte_in;
   logic               last_ff, last_in;
   logic               eos_ff, eos_in;

   // Decode of the current input word
   logic               is_drop;
   logic               is_tab;
   logic [WIDTH_W-1:0] fill_wide;
   logic [PHASE_W-1:0] fill_amt;
   logic [WIDTH_W-1:0] phase_inc;
   logic [PHASE_W-1:0] phase_adv;
   logic [BYTE_W-1:0]  copy_byte;
   logic [WIDE_W-1:0]  red_sub;
   logic [WIDE_W-1:0]  red_phase;

   always_comb begin
      is_drop   = (mode_ff == MODE_STRIP || mode_ff == MODE_FIX) && (in_byte == CH_FILL);
      is_tab    = (mode_ff == MODE_EXPAND || mode_ff == MODE_FIX) && (in_byte == CH_TAB);
      fill_wide = width_ff - WIDTH_W'(phase_ff) - WIDTH_W'(1);
      fill_amt  = fill_wide[PHASE_W-1:0];
      phase_inc = WIDTH_W'(phase_ff) + WIDTH_W'(1);
      phase_adv = (phase_inc >= width_ff) ? '0 : phase_inc[PHASE_W-1:0];
      copy_byte = in_byte;
      if (mode_ff == MODE_REPLACE && (in_byte == CH_TAB || in_byte == CH_FILL)) begin
         copy_byte = CH_SPACE;
      end
      red_sub   = WIDE_W'(width_ff) << shift_ff;
      red_phase = WIDE_W'(phase_ff);
   end

   // Status back to the controller
   always_comb begin
      status.can_load  = !rsp_valid_ff || rsp_ready;
      status.tab_run   = !is_drop && is_tab && (fill_amt != '0);
      status.fill_last = (fill_cnt_ff == PHASE_W'(1));
      status.red_done  = (shift_ff == '0);
   end

   // Register writes, saturating the tab width into range
   always_comb begin
      width_in = width_ff;
      mode_in  = mode_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_TAB_WIDTH: begin
               if (csr_data == '0) begin
                  width_in = WIDTH_W'(1);
               end else if (csr_data > MAX_RAW) begin
                  width_in = WIDTH_W'(MAX_TAB_WIDTH);
               end else begin
                  width_in = csr_data[WIDTH_W-1:0];
               end
            end
            CSR_MODE: mode_in = mode_type'(csr_data[1:0]);
            default: ;
         endcase
      end
   end

   // Phase, filler run, reduction and output word
   always_comb begin
      phase_in     = phase_ff;
      fill_cnt_in  = fill_cnt_ff;
      eos_hold_in  = eos_hold_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      has_byte_in  = has_byte_ff;
      last_in      = last_ff;
      eos_in       = eos_ff;

      if (csr_wr && csr_index == CSR_TAB_WIDTH) begin
         shift_in = SH_W'(PHASE_W - 1);
      end

      // Restoring remainder: subtract width << shift where it fits
      if (cmd.red_step) begin
         if (red_phase >= red_sub) begin
            phase_in = PHASE_W'(red_phase - red_sub);
         end
         if (shift_ff != '0) begin
            shift_in = shift_ff - SH_W'(1);
         end
      end

      if (cmd.accept) begin
         priority if (is_drop) begin
            if (in_eos) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = CH_NONE;
               has_byte_in  = 1'b0;
               last_in      = 1'b1;
               eos_in       = 1'b1;
               phase_in     = '0;
            end
         end else if (is_tab) begin
            rsp_valid_in = 1'b1;
            out_byte_in  = CH_TAB;
            has_byte_in  = 1'b1;
            last_in      = (fill_amt == '0);
            eos_in       = in_eos && (fill_amt == '0);
            fill_cnt_in  = fill_amt;
            eos_hold_in  = in_eos;
            phase_in     = '0;
         end else begin
            rsp_valid_in = 1'b1;
            out_byte_in  = copy_byte;
            has_byte_in  = 1'b1;
            last_in      = 1'b1;
            eos_in       = in_eos;
            phase_in     = in_eos ? '0 : phase_adv;
         end
      end

      if (cmd.fill_word) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = CH_FILL;
         has_byte_in  = 1'b1;
         last_in      = status.fill_last;
         eos_in       = eos_hold_ff && status.fill_last;
         fill_cnt_in  = fill_cnt_ff - PHASE_W'(1);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_W'(RESET_WIDTH);
         mode_ff      <= MODE_RESET;
         phase_ff     <= '0;
         fill_cnt_ff  <= '0;
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         fill_cnt_ff  <= fill_cnt_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      eos_hold_ff <= eos_hold_in;
      out_byte_ff <= out_byte_in;
      has_byte_ff <= has_byte_in;
      last_ff     <= last_in;
      eos_ff      <= eos_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign out_byte    = out_byte_ff;
   assign has_byte    = has_byte_ff;
   assign last_of_run = last_ff;
   assign out_eos     = eos_ff;

   // Phase is always below the tab width when a word is taken
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (WIDTH_W'(phase_ff) < width_ff))
      else $error("column phase not reduced below tab width");

   // Filler words only come while the run counter is live
   a_fill_live: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_word |-> (fill_cnt_ff != '0))
      else $error("filler emitted with empty run counter");

   // A dropped filler inside the line leaves no result behind
   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && is_drop && !in_eos) |=> !rsp_valid_ff)
      else $error("dropped filler produced a result word");

   // The last word of a string always closes its run
   a_eos_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && eos_ff) |-> last_ff)
      else $error("string end on a word that is not last of its run");

endmodule

`default_nettype wire

// File: design/tab_extension_stream_converter.sv
// Tab stop converter: expands, strips, fixes or replaces tabs and 0xFF fillers per line.
//
// Channels: req_chan takes one line byte per word with end_of_string on the
// last byte. rsp_chan gives the result words; last_of_run marks the final word
// caused by one input word and out_end_of_string the final word of the line.
// csr_chan writes tab_width (index 0, saturated to 1..MAX_TAB_WIDTH) and
// mode (index 1); write it only while no line data is in flight.
// A result word is registered and appears in the cycle after its input word is taken.
// Throughput: one result word per cycle while rsp_chan.ready is high. A plain byte
// gives one word, a dropped filler none unless it ends the line, and an expanded tab
// (width - column) words while the filler counter runs and the input is held off.
// A tab_width write taken while idle starts a phase reduction, one restoring
// compare/subtract step per bit of the column phase, during which neither port
// is ready.
// Reset: tab_width 8, mode strip-then-expand, column 0, output empty.
// Stalls: the output register holds its word while rsp_chan.ready is low and
// no new input or filler is taken until it drains.
`default_nettype none

module tab_extension_stream_converter
   import tes_pkg::*;
#(
   parameter int MAX_TAB_WIDTH = MAX_TAB_WIDTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tes_req_if.sink    req_chan,
   tes_rsp_if.source  rsp_chan,
   tes_csr_if.sink    csr_chan
);

   cmd_type    cmd;
   status_type status;
   logic       csr_wr;
   logic       csr_width_wr;

   // Register write decode
   assign csr_wr       = csr_chan.valid && csr_chan.ready;
   assign csr_width_wr = csr_wr && (csr_chan.index == CSR_TAB_WIDTH);

   tes_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .csr_width_wr (csr_width_wr),
      .status       (status),
      .req_ready    (req_chan.ready),
      .csr_ready    (csr_chan.ready),
      .cmd          (cmd)
   );

   tes_dp #(
      .MAX_TAB_WIDTH (MAX_TAB_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr      (csr_wr),
      .csr_index   (csr_chan.index),
      .csr_data    (csr_chan.data),
      .in_byte     (req_chan.in_byte),
      .in_eos      (req_chan.end_of_string),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .out_byte    (rsp_chan.out_byte),
      .has_byte    (rsp_chan.has_byte),
      .last_of_run (rsp_chan.last_of_run),
      .out_eos     (rsp_chan.out_end_of_string)
   );

endmodule

`default_nettype wire

// File: dv/tab_extension_stream_converter_tb.sv
// Testbench for the tab stop converter: directed table, random lines and a built-in predictor.
module tab_extension_stream_converter_tb
   import tes_pkg::*;
();

   localparam int CLK_HALF        = 4;
   localparam int RESET_CYCLES    = 12;
   localparam int RANDOM_WORDS    = 136;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int MAX_REPORTS     = 10;
   localparam int PREDICTED       = -1;   // row expectation comes from the predictor

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              has_byte;
      logic              last_of_run;
      logic              out_end_of_string;
   } out_word_type;

   typedef enum logic {ROW_REG, ROW_BYTE} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      csr_index_type         reg_index;
      logic [CSR_DATA_W-1:0] reg_data;
      logic [BYTE_W-1:0]     in_byte;
      logic                  eos;
      int                    typed_count;  // 0 or 1 words typed in, or PREDICTED
      logic [BYTE_W-1:0]     typed_byte;
      logic                  typed_has;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   tes_req_if req_chan ();
   tes_rsp_if rsp_chan ();
   tes_csr_if csr_chan ();

   tab_extension_stream_converter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #CLK_HALF clock = ~clock;

   // Predictor state and the store of expected words
   logic [CSR_DATA_W-1:0] cur_tab_width;
   mode_type              cur_mode;
   logic [5:0]            column_pos;
   out_word_type          expected_words[$];
   stim_row_type          stim_rows[$];

   int mismatch_count  = 0;
   int cycle_count     = 0;
   int hold_off_cycles = 0;
   int send_idle_pct   = 18;
   int recv_idle_pct   = 72;

   // Tab width in use: zero acts as one, large values saturate
   function automatic int stop_width();
      if (cur_tab_width == '0) return 1;
      if (int'(cur_tab_width) > MAX_TAB_WIDTH_DEFAULT) return MAX_TAB_WIDTH_DEFAULT;
      return int'(cur_tab_width);
   endfunction

   // Words caused by one input byte; advances the column
   function automatic void predict_output(input logic [BYTE_W-1:0] b, input logic e,
                                          output out_word_type words[$]);
      int           width;
      int           pos;
      out_word_type wd;
      words = {};
      width = stop_width();
      pos   = int'(column_pos) % width;
      if ((cur_mode == MODE_STRIP || cur_mode == MODE_FIX) && b == CH_FILL) begin
         // dropped filler; only the line end leaves a bare marker
         if (e) begin
            wd = '{CH_NONE, 1'b0, 1'b0, 1'b0};
            words.push_back(wd);
         end
      end else if ((cur_mode == MODE_EXPAND || cur_mode == MODE_FIX) && b == CH_TAB) begin
         wd = '{CH_TAB, 1'b1, 1'b0, 1'b0};
         words.push_back(wd);
         for (int i = 0; i < width - pos - 1; i++) begin
            wd = '{CH_FILL, 1'b1, 1'b0, 1'b0};
            words.push_back(wd);
         end
         pos = 0;
      end else begin
         wd = '{b, 1'b1, 1'b0, 1'b0};
         if (cur_mode == MODE_REPLACE && (b == CH_TAB || b == CH_FILL)) wd.out_byte = CH_SPACE;
         words.push_back(wd);
         pos = pos + 1;
         if (pos >= width) pos = 0;
      end
      if (words.size() > 0) begin
         words[words.size()-1].last_of_run       = 1'b1;
         words[words.size()-1].out_end_of_string = e;
      end
      column_pos = e ? 6'd0 : 6'(pos);
   endfunction

   function automatic void apply_reg(input csr_index_type idx,
                                     input logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_TAB_WIDTH) cur_tab_width = data;
      else cur_mode = mode_type'(data[1:0]);
   endfunction

   // Table builders
   function automatic void row_reg(input csr_index_type idx, input int value);
      stim_row_type r;
      r.kind        = ROW_REG;
      r.reg_index   = idx;
      r.reg_data    = CSR_DATA_W'(value);
      r.in_byte     = CH_NONE;
      r.eos         = 1'b0;
      r.typed_count = PREDICTED;
      r.typed_byte  = CH_NONE;
      r.typed_has   = 1'b0;
      stim_rows.push_back(r);
   endfunction

   function automatic void row_typed(input logic [BYTE_W-1:0] b, input logic e,
                                     input int count, input logic [BYTE_W-1:0] tb,
                                     input logic th);
      stim_row_type r;
      r.kind        = ROW_BYTE;
      r.reg_index   = CSR_TAB_WIDTH;
      r.reg_data    = '0;
      r.in_byte     = b;
      r.eos         = e;
      r.typed_count = count;
      r.typed_byte  = tb;
      r.typed_has   = th;
      stim_rows.push_back(r);
   endfunction

   function automatic void row_byte(input logic [BYTE_W-1:0] b, input logic e);
      row_typed(b, e, PREDICTED, CH_NONE, 1'b0);
   endfunction

   // Offer one byte, wait for it to be taken, queue its expected words
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic e, input int typed_count,
                            input logic [BYTE_W-1:0] tb, input logic th);
      out_word_type words[$];
      out_word_type wd;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.in_byte       <= b;
      req_chan.end_of_string <= e;
      do @(posedge clock); while (!req_chan.ready);
      predict_output(b, e, words);
      if (typed_count != PREDICTED) begin
         words = {};
         if (typed_count > 0) begin
            wd = '{tb, th, 1'b1, e};
            words.push_back(wd);
         end
      end
      foreach (words[i]) expected_words.push_back(words[i]);
   endtask

   // Stop the input and let the block drain before a register write
   task automatic quiesce();
      req_chan.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // valid is left high so a second write can follow at once
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      apply_reg(idx, data);
   endtask

   // Random width and/or mode; widths mostly small, with zero and oversize now and then
   task automatic reconfigure_random();
      int                    pick;
      int                    r;
      logic [CSR_DATA_W-1:0] width;
      mode_type              m;
      pick = $urandom_range(0, 2);
      r    = $urandom_range(0, 99);
      if (r < 60) width = CSR_DATA_W'($urandom_range(1, 8));
      else if (r < 70) width = '0;
      else if (r < 80) width = CSR_DATA_W'($urandom_range(64, 127));
      else width = CSR_DATA_W'($urandom_range(9, 63));
      m = mode_type'($urandom_range(0, 3));
      quiesce();
      if (pick != 1) write_reg(CSR_TAB_WIDTH, width);
      if (pick != 0) write_reg(CSR_MODE, CSR_DATA_W'(m));
      csr_chan.valid <= 1'b0;
   endtask

   // Receiver: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_chan.ready  <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Result checker
   always @(posedge clock) begin
      out_word_type got;
      out_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.out_byte, rsp_chan.has_byte, rsp_chan.last_of_run,
                 rsp_chan.out_end_of_string};
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected word: byte %h has %b last %b eos %b", got.out_byte,
                        got.has_byte, got.last_of_run, got.out_end_of_string);
         end else begin
            want = expected_words.pop_front();
            if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
                got.last_of_run !== want.last_of_run ||
                got.out_end_of_string !== want.out_end_of_string) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: exp byte %h has %b last %b eos %b, got %h %b %b %b",
                           want.out_byte, want.has_byte, want.last_of_run,
                           want.out_end_of_string, got.out_byte, got.has_byte,
                           got.last_of_run, got.out_end_of_string);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int                random_done;
      int                idle_phase;
      int                len;
      int                fill_left;
      int                r;
      logic [BYTE_W-1:0] b;
      logic              e;

      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.in_byte       <= CH_NONE;
      req_chan.end_of_string <= 1'b0;
      csr_chan.valid         <= 1'b0;
      csr_chan.index         <= CSR_TAB_WIDTH;
      csr_chan.data          <= '0;
      cur_tab_width = CSR_DATA_W'(TAB_WIDTH_RESET);
      cur_mode      = MODE_RESET;
      column_pos    = '0;

      // Directed table; reset mode is fix, width 8
      row_typed(8'h41, 1'b0, 1, 8'h41, 1'b1);
      row_byte(CH_TAB, 1'b0);
      row_typed(CH_FILL, 1'b0, 0, CH_NONE, 1'b0);      // dropped filler
      row_typed(8'h00, 1'b0, 1, 8'h00, 1'b1);          // zero byte is plain data
      row_typed(CH_FILL, 1'b1, 1, CH_NONE, 1'b0);      // bare end marker
      row_byte(CH_TAB, 1'b1);
      row_reg(CSR_MODE, MODE_EXPAND);
      row_typed(CH_FILL, 1'b0, 1, CH_FILL, 1'b1);      // filler copied in expand
      row_byte(CH_TAB, 1'b0);
      row_typed(8'h7E, 1'b1, 1, 8'h7E, 1'b1);
      row_reg(CSR_TAB_WIDTH, MAX_TAB_WIDTH_DEFAULT);
      row_byte(CH_TAB, 1'b1);                          // longest run
      row_reg(CSR_TAB_WIDTH, 0);
      row_typed(CH_TAB, 1'b0, 1, CH_TAB, 1'b1);        // width zero acts as one
      row_typed(8'h42, 1'b1, 1, 8'h42, 1'b1);
      row_reg(CSR_TAB_WIDTH, 127);                     // saturates to max width
      row_typed(8'h01, 1'b0, 1, 8'h01, 1'b1);
      row_byte(CH_TAB, 1'b1);
      row_reg(CSR_MODE, MODE_STRIP);
      row_typed(CH_TAB, 1'b0, 1, CH_TAB, 1'b1);
      row_typed(CH_FILL, 1'b0, 0, CH_NONE, 1'b0);
      row_typed(CH_FILL, 1'b1, 1, CH_NONE, 1'b0);
      row_reg(CSR_MODE, MODE_REPLACE);
      row_typed(CH_TAB, 1'b0, 1, CH_SPACE, 1'b1);
      row_typed(CH_FILL, 1'b0, 1, CH_SPACE, 1'b1);
      row_typed(8'h80, 1'b1, 1, 8'h80, 1'b1);
      row_reg(CSR_TAB_WIDTH, 5);
      row_reg(CSR_MODE, MODE_FIX);
      row_byte(8'h61, 1'b0);
      row_byte(8'h62, 1'b0);
      row_byte(8'h63, 1'b0);
      row_reg(CSR_TAB_WIDTH, 2);                       // width change mid-line
      row_byte(CH_TAB, 1'b1);
      row_typed(8'hFE, 1'b1, 1, 8'hFE, 1'b1);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the table; back-to-back register rows share one write burst
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_REG) begin
            if (i == 0 || stim_rows[i-1].kind != ROW_REG) quiesce();
            write_reg(stim_rows[i].reg_index, stim_rows[i].reg_data);
            if (i == stim_rows.size() - 1 || stim_rows[i+1].kind != ROW_REG)
               csr_chan.valid <= 1'b0;
         end else begin
            send_byte(stim_rows[i].in_byte, stim_rows[i].eos, stim_rows[i].typed_count,
                      stim_rows[i].typed_byte, stim_rows[i].typed_has);
         end
      end

      // Random lines: text, tabs, filler runs after tabs and stray fillers
      random_done = 0;
      idle_phase  = 0;
      while (random_done < RANDOM_WORDS) begin
         if ($urandom_range(0, 2) == 0) reconfigure_random();
         if (idle_phase == 0 && random_done >= RANDOM_WORDS / 3) begin
            idle_phase    = 1;
            send_idle_pct = 72;
            recv_idle_pct = 18;
         end else if (idle_phase == 1 && random_done >= 2 * RANDOM_WORDS / 3) begin
            // no idling from here on; first a long receiver hold-off to fill the block
            idle_phase      = 2;
            send_idle_pct   = 0;
            recv_idle_pct   = 0;
            hold_off_cycles <= HOLD_OFF_CYCLES;
         end
         len       = $urandom_range(1, 12);
         fill_left = 0;
         for (int k = 0; k < len; k++) begin
            if (k > 0 && k == len / 2 && $urandom_range(0, 7) == 0) reconfigure_random();
            if (fill_left > 0) begin
               b = CH_FILL;
               fill_left--;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 25) begin
                  b = CH_TAB;
                  if ($urandom_range(0, 1) == 1) fill_left = $urandom_range(1, 7);
               end else if (r < 35) begin
                  b = CH_FILL;
               end else if (r < 70) begin
                  b = BYTE_W'($urandom_range(32, 126));
               end else begin
                  b = BYTE_W'($urandom_range(1, 255));
               end
            end
            e = (k == len - 1);
            send_byte(b, e, PREDICTED, CH_NONE, 1'b0);
            random_done++;
         end
      end

      // Drain and report
      req_chan.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
